@@ rtl/sphere_box_overlap_test_core_macros.svh @@
// assertion macros shared by the sphere versus box overlap test rtl
`ifndef SPHERE_BOX_OVERLAP_TEST_CORE_MACROS_SVH
`define SPHERE_BOX_OVERLAP_TEST_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SBOT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sbot assertion failed");
`define SBOT_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sbot reset assertion failed");
`else
`define SBOT_ASSERT(label, clk, rst, prop)
`define SBOT_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ rtl/sbot_pkg.sv @@
// shared types and constants for the sphere versus box overlap test
`default_nettype none
package sbot_pkg;

  // per-axis containment flags
  typedef struct packed {
    logic inbox;
    logic inwide;
  } sbot_flags_t;

  // register stages from input to output register
  localparam int unsigned PIPE_STAGES = 5;

endpackage
`default_nettype wire

@@ rtl/sphere_box_overlap_test_core.sv @@
// Sphere versus axis-aligned box overlap test. Takes one transaction per clock and returns
// one overlap bit per transaction, in order. The five
// register stages (face bounds, range checks, nearest face distance, squaring, sum and
// compare) move together: while the output register holds a result that is stalled the
// whole pipeline holds and in_stall is raised, so throughput is one transaction per cycle
// whenever the output side takes results. Reset clears only the valid bits.
`default_nettype none
`include "sphere_box_overlap_test_core_macros.svh"
module sphere_box_overlap_test_core #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  sphere_x,
  input  logic signed [COORD_BITS-1:0]  sphere_y,
  input  logic signed [COORD_BITS-1:0]  sphere_z,
  input  logic        [COORD_BITS-2:0]  sphere_radius,
  input  logic signed [COORD_BITS-1:0]  box_center_x,
  input  logic signed [COORD_BITS-1:0]  box_center_y,
  input  logic signed [COORD_BITS-1:0]  box_center_z,
  input  logic        [COORD_BITS-2:0]  half_size_x,
  input  logic        [COORD_BITS-2:0]  half_size_y,
  input  logic        [COORD_BITS-2:0]  half_size_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          overlap
);
  import sbot_pkg::*;

  localparam int unsigned QW = 2*COORD_BITS - 2;
  localparam int unsigned SW = 2*COORD_BITS;

  logic                   en;
  logic [PIPE_STAGES-1:0] vld;

  logic [COORD_BITS-2:0]  r1, r2, r3;
  sbot_flags_t            fx, fy, fz;
  logic [COORD_BITS-2:0]  dx, dy, dz;

  sbot_flags_t            fx4, fy4, fz4;
  logic [QW-1:0]          dsq_x, dsq_y, dsq_z, rsq;

  logic [SW-1:0]          sum_xy, sum_xz, sum_yz, sum_xyz, rsq_e;
  logic                   face_hit, edge_hit, corner_hit;

  // whole pipeline advances unless a finished result is held
  assign en       = !vld[PIPE_STAGES-1] || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_STAGES-2:0], in_valid};
    end
  end

  // radius travels alongside the axis stages
  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= sphere_radius;
      r2 <= r1;
      r3 <= r2;
    end
  end

  sbot_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk(clk), .en(en), .p(sphere_x), .c(box_center_x), .h(half_size_x),
    .r(sphere_radius), .flags(fx), .gap(dx)
  );

  sbot_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk(clk), .en(en), .p(sphere_y), .c(box_center_y), .h(half_size_y),
    .r(sphere_radius), .flags(fy), .gap(dy)
  );

  sbot_axis #(.COORD_BITS(COORD_BITS)) u_axis_z (
    .clk(clk), .en(en), .p(sphere_z), .c(box_center_z), .h(half_size_z),
    .r(sphere_radius), .flags(fz), .gap(dz)
  );

  // stage 4: squares
  always_ff @(posedge clk) begin
    if (en) begin
      fx4   <= fx;
      fy4   <= fy;
      fz4   <= fz;
      dsq_x <= QW'(dx) * QW'(dx);
      dsq_y <= QW'(dy) * QW'(dy);
      dsq_z <= QW'(dz) * QW'(dz);
      rsq   <= QW'(r3) * QW'(r3);
    end
  end

  // stage 5: sums of squares against radius squared, strict
  assign sum_xy  = SW'(dsq_x) + SW'(dsq_y);
  assign sum_xz  = SW'(dsq_x) + SW'(dsq_z);
  assign sum_yz  = SW'(dsq_y) + SW'(dsq_z);
  assign sum_xyz = sum_xy + SW'(dsq_z);
  assign rsq_e   = SW'(rsq);

  assign face_hit = (fx4.inwide && fy4.inbox  && fz4.inbox)  ||
                    (fx4.inbox  && fy4.inwide && fz4.inbox)  ||
                    (fx4.inbox  && fy4.inbox  && fz4.inwide);

  assign edge_hit = (fx4.inwide && fy4.inwide && fz4.inbox  && (sum_xy < rsq_e)) ||
                    (fx4.inwide && fy4.inbox  && fz4.inwide && (sum_xz < rsq_e)) ||
                    (fx4.inbox  && fy4.inwide && fz4.inwide && (sum_yz < rsq_e));

  assign corner_hit = fx4.inwide && fy4.inwide && fz4.inwide && (sum_xyz < rsq_e);

  always_ff @(posedge clk) begin
    if (en) begin
      overlap <= face_hit || edge_hit || corner_hit;
    end
  end

  // an accepted transaction always lands in the first stage
  `SBOT_ASSERT(a_accept_enters, clk, rst, in_valid && !in_stall |=> vld[0])
  // a held result freezes every stage
  `SBOT_ASSERT(a_hold_freezes, clk, rst, out_valid && out_stall |=> $stable(vld))
  // a delivered result is not shown again when nothing follows it
  `SBOT_ASSERT(a_no_repeat, clk, rst,
    out_valid && !out_stall && !vld[PIPE_STAGES-2] |=> !out_valid)
  // reset empties the pipeline
  `SBOT_ASSERT_RST(a_reset_empty, clk, rst |=> (vld == '0))

endmodule
`default_nettype wire

@@ rtl/sbot_axis.sv @@
// one axis: face bounds, containment flags and nearest face distance over three stages
`default_nettype none
module sbot_axis #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_BITS-1:0]  p,
  input  logic signed [COORD_BITS-1:0]  c,
  input  logic        [COORD_BITS-2:0]  h,
  input  logic        [COORD_BITS-2:0]  r,
  output sbot_pkg::sbot_flags_t         flags,
  output logic        [COORD_BITS-2:0]  gap
);
  import sbot_pkg::*;

  localparam int unsigned W = COORD_BITS + 2;

  logic signed [W-1:0] p_e, c_e, h_e, r_e;
  logic signed [W-1:0] p1, lo1, hi1, lo_w1, hi_w1;
  logic signed [W-1:0] da2, db2;
  sbot_flags_t         flags2;
  logic        [W-1:0] ua, ub, m;

  assign p_e = W'(p);
  assign c_e = W'(c);
  assign h_e = W'(h);
  assign r_e = W'(r);

  // stage 1: box faces and faces of the box widened by the radius
  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= p_e;
      lo1   <= c_e - h_e;
      hi1   <= c_e + h_e;
      lo_w1 <= c_e - h_e - r_e;
      hi_w1 <= c_e + h_e + r_e;
    end
  end

  // stage 2: inclusive range checks and signed distances to both faces
  always_ff @(posedge clk) begin
    if (en) begin
      flags2.inbox  <= (lo1 <= p1) && (p1 <= hi1);
      flags2.inwide <= (lo_w1 <= p1) && (p1 <= hi_w1);
      da2           <= p1 - lo1;
      db2           <= hi1 - p1;
    end
  end

  assign ua = da2[W-1] ? W'(-da2) : W'(da2);
  assign ub = db2[W-1] ? W'(-db2) : W'(db2);
  assign m  = (ua < ub) ? ua : ub;

  // stage 3: nearer face, saturated; saturation only hits axes outside the widened box
  always_ff @(posedge clk) begin
    if (en) begin
      flags <= flags2;
      gap   <= (|m[W-1:COORD_BITS-1]) ? '1 : m[COORD_BITS-2:0];
    end
  end

endmodule
`default_nettype wire
